>>> rtl/lsc_pkg.sv
`timescale 1ns / 1ps

package lsc_pkg;

  localparam int TOP_FLOOR = 15;
  localparam int FLOOR_W   = 6;
  localparam int MAP_W     = TOP_FLOOR + 1;
  localparam int IDX_W     = (MAP_W > 1) ? $clog2(MAP_W) : 1;
  localparam int CMD_W     = 4;
  localparam int UNITS_W   = 10;
  localparam int RIDERS_W  = 7;
  localparam int KIND_W    = 2;

  localparam logic [CMD_W-1:0] CMD_CAR_REQ   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_HALL_CALL = 4'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE_TO   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_BOARD     = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DROP      = 4'd4;
  localparam logic [CMD_W-1:0] CMD_EMERG_ON  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_EMERG_OFF = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_SET_STAT  = 4'd8;

  localparam logic [KIND_W-1:0] KIND_NORMAL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STAFF   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOCTOR  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PATIENT = 2'd3;

  localparam logic [UNITS_W-1:0] CAP_RESET = 10'd100;
  localparam logic [RIDERS_W-1:0] RIDERS_MAX = 7'd127;

  typedef struct packed {
    logic latch;
    logic exec;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic move_far;
    logic step_last;
  } dp_stat_t;

  function automatic logic [UNITS_W-1:0] units_for(input logic [KIND_W-1:0] kind);
    logic [UNITS_W-1:0] u;
    case (kind)
      KIND_PATIENT: u = 10'd50;
      KIND_DOCTOR:  u = 10'd30;
      KIND_STAFF:   u = 10'd20;
      KIND_NORMAL:  u = 10'd10;
      default:      u = 10'd10;
    endcase
    return u;
  endfunction

endpackage

>>> rtl/lsc_ctrl.sv
`timescale 1ns / 1ps

module lsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  lsc_pkg::dp_stat_t  stat,
  output lsc_pkg::ctrl_cmd_t cmd,
  output logic               busy
);
  import lsc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_MOVE = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.move_far ? ST_MOVE : ST_IDLE;
      end
      ST_MOVE: begin
        cmd.step = 1'b1;
        if (stat.step_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> rtl/lsc_dp.sv
`timescale 1ns / 1ps

module lsc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lsc_pkg::ctrl_cmd_t             cmd,
  output lsc_pkg::dp_stat_t              stat,
  input  logic [lsc_pkg::CMD_W-1:0]      in_cmd,
  input  logic [lsc_pkg::FLOOR_W-1:0]    in_floor_number,
  input  logic                           in_going_up,
  input  logic [lsc_pkg::KIND_W-1:0]     in_person_kind,
  input  logic                           in_busy_value,
  input  logic                           cfg_wr_en,
  input  logic [lsc_pkg::UNITS_W-1:0]    cfg_wr_data,
  output logic                           out_valid,
  output logic [lsc_pkg::FLOOR_W-1:0]    out_car_floor,
  output logic                           out_doors_cycled,
  output logic                           out_alighting,
  output logic                           out_pickup,
  output logic                           out_accepted,
  output logic [lsc_pkg::UNITS_W-1:0]    out_space_used,
  output logic [lsc_pkg::RIDERS_W-1:0]   out_rider_count,
  output logic                           out_emergency_active,
  output logic                           out_car_busy,
  output logic                           out_last
);
  import lsc_pkg::*;

  // car state
  logic [FLOOR_W-1:0]  floor_r, floor_nxt;
  logic [MAP_W-1:0]    car_r, car_nxt;
  logic [MAP_W-1:0]    up_r, up_nxt;
  logic [MAP_W-1:0]    dn_r, dn_nxt;
  logic [UNITS_W-1:0]  units_r, units_nxt;
  logic [RIDERS_W-1:0] riders_r, riders_nxt;
  logic                emerg_r, emerg_nxt;
  logic                bflag_r, bflag_nxt;
  logic [UNITS_W-1:0]  cap_r;

  // latched transaction
  logic [CMD_W-1:0]    op_r;
  logic [FLOOR_W-1:0]  tgt_r;
  logic                hup_r;
  logic [KIND_W-1:0]   kind_r;
  logic                bval_r;
  logic                dir_r, dir_nxt;

  logic                emit;
  logic                doors, alight, pick, acc, last;
  logic [FLOOR_W-1:0]  nf;
  logic [FLOOR_W-1:0]  tgt_clamp;
  logic [MAP_W-1:0]    tbit, nbit;
  logic [UNITS_W-1:0]  need;
  logic [UNITS_W:0]    board_sum;

  assign tgt_clamp = (in_floor_number > FLOOR_W'(TOP_FLOOR)) ? FLOOR_W'(TOP_FLOOR)
                                                             : in_floor_number;
  assign nf        = dir_r ? floor_r + 1'b1 : floor_r - 1'b1;
  assign tbit      = MAP_W'(1) << tgt_r[IDX_W-1:0];
  assign nbit      = MAP_W'(1) << nf[IDX_W-1:0];
  assign need      = units_for(kind_r);
  assign board_sum = {1'b0, units_r} + {1'b0, need};

  assign stat.move_far  = (op_r == CMD_MOVE_TO) && (tgt_r != floor_r);
  assign stat.step_last = (nf == tgt_r);

  always_comb begin
    floor_nxt  = floor_r;
    car_nxt    = car_r;
    up_nxt     = up_r;
    dn_nxt     = dn_r;
    units_nxt  = units_r;
    riders_nxt = riders_r;
    emerg_nxt  = emerg_r;
    bflag_nxt  = bflag_r;
    dir_nxt    = dir_r;
    emit       = 1'b0;
    doors      = 1'b0;
    alight     = 1'b0;
    pick       = 1'b0;
    acc        = 1'b0;
    last       = 1'b1;
    if (cmd.exec) begin
      emit = 1'b1;
      case (op_r)
        CMD_CAR_REQ: begin
          if ((tgt_r != floor_r) && ((car_r & tbit) == '0)) begin
            car_nxt = car_r | tbit;
            acc     = 1'b1;
          end
        end
        CMD_HALL_CALL: begin
          if (hup_r) begin
            if ((up_r & tbit) == '0) begin
              up_nxt = up_r | tbit;
              acc    = 1'b1;
            end
          end else begin
            if ((dn_r & tbit) == '0) begin
              dn_nxt = dn_r | tbit;
              acc    = 1'b1;
            end
          end
        end
        CMD_MOVE_TO: begin
          if (tgt_r != floor_r) begin
            emit    = 1'b0;
            dir_nxt = (tgt_r > floor_r);
          end
        end
        CMD_BOARD: begin
          if ((riders_r < RIDERS_MAX) && (board_sum <= {1'b0, cap_r})) begin
            units_nxt  = board_sum[UNITS_W-1:0];
            riders_nxt = riders_r + 1'b1;
            acc        = 1'b1;
          end
        end
        CMD_DROP: begin
          if (riders_r != '0) begin
            units_nxt  = (units_r > need) ? units_r - need : '0;
            riders_nxt = riders_r - 1'b1;
            acc        = 1'b1;
          end
        end
        CMD_EMERG_ON: begin
          emerg_nxt = 1'b1;
          bflag_nxt = 1'b1;
          car_nxt   = '0;
          up_nxt    = '0;
          dn_nxt    = '0;
        end
        CMD_EMERG_OFF: emerg_nxt = 1'b0;
        CMD_CLEAR:     car_nxt = car_r & ~tbit;
        CMD_SET_STAT:  bflag_nxt = bval_r;
        default: ;
      endcase
    end else if (cmd.step) begin
      emit      = 1'b1;
      floor_nxt = nf;
      bflag_nxt = 1'b1;
      last      = (nf == tgt_r);
      if ((nf != tgt_r) && !emerg_r) begin
        if ((car_r & nbit) != '0) begin
          car_nxt = car_r & ~nbit;
          alight  = 1'b1;
        end
        if (units_r < cap_r) begin
          if (dir_r) begin
            if ((up_r & nbit) != '0) begin
              up_nxt = up_r & ~nbit;
              pick   = 1'b1;
            end
          end else begin
            if ((dn_r & nbit) != '0) begin
              dn_nxt = dn_r & ~nbit;
              pick   = 1'b1;
            end
          end
        end
      end
      doors = alight | pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r   <= '0;
      car_r     <= '0;
      up_r      <= '0;
      dn_r      <= '0;
      units_r   <= '0;
      riders_r  <= '0;
      emerg_r   <= 1'b0;
      bflag_r   <= 1'b0;
      cap_r     <= CAP_RESET;
      dir_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      floor_r   <= floor_nxt;
      car_r     <= car_nxt;
      up_r      <= up_nxt;
      dn_r      <= dn_nxt;
      units_r   <= units_nxt;
      riders_r  <= riders_nxt;
      emerg_r   <= emerg_nxt;
      bflag_r   <= bflag_nxt;
      dir_r     <= dir_nxt;
      out_valid <= emit;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // transaction fields and result payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_cmd;
      tgt_r  <= tgt_clamp;
      hup_r  <= in_going_up;
      kind_r <= in_person_kind;
      bval_r <= in_busy_value;
    end
    if (emit) begin
      out_car_floor        <= floor_nxt;
      out_doors_cycled     <= doors;
      out_alighting        <= alight;
      out_pickup           <= pick;
      out_accepted         <= acc;
      out_space_used       <= units_nxt;
      out_rider_count      <= riders_nxt;
      out_emergency_active <= emerg_nxt;
      out_car_busy         <= bflag_nxt;
      out_last             <= last;
    end
  end

endmodule

>>> rtl/lift_stop_controller.sv
`timescale 1ns / 1ps

// channel   ports                          handshake
// input     in_cmd .. in_busy_value        taken when start high and busy low
// result    out_car_floor .. out_last      one cycle, marked by out_valid
// config    cfg_wr_data                    written when cfg_wr_en high
//
// a taken command executes in the next cycle; a single result shows in the cycle after
// single-result commands hold busy for one cycle; a new transaction waits for busy low
// move-to steps the car one floor per cycle in the floor stepper, one result per floor
// synchronous active-low reset: ground floor, no stops or calls, capacity 100
// the receiver cannot stall; every out_valid cycle is a delivered result

module lift_stop_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [lsc_pkg::CMD_W-1:0]      in_cmd,
  input  logic [lsc_pkg::FLOOR_W-1:0]    in_floor_number,
  input  logic                           in_going_up,
  input  logic [lsc_pkg::KIND_W-1:0]     in_person_kind,
  input  logic                           in_busy_value,
  input  logic                           cfg_wr_en,
  input  logic [lsc_pkg::UNITS_W-1:0]    cfg_wr_data,
  output logic                           out_valid,
  output logic [lsc_pkg::FLOOR_W-1:0]    out_car_floor,
  output logic                           out_doors_cycled,
  output logic                           out_alighting,
  output logic                           out_pickup,
  output logic                           out_accepted,
  output logic [lsc_pkg::UNITS_W-1:0]    out_space_used,
  output logic [lsc_pkg::RIDERS_W-1:0]   out_rider_count,
  output logic                           out_emergency_active,
  output logic                           out_car_busy,
  output logic                           out_last
);
  import lsc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lsc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lsc_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_cmd               (in_cmd),
    .in_floor_number      (in_floor_number),
    .in_going_up          (in_going_up),
    .in_person_kind       (in_person_kind),
    .in_busy_value        (in_busy_value),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .out_valid            (out_valid),
    .out_car_floor        (out_car_floor),
    .out_doors_cycled     (out_doors_cycled),
    .out_alighting        (out_alighting),
    .out_pickup           (out_pickup),
    .out_accepted         (out_accepted),
    .out_space_used       (out_space_used),
    .out_rider_count      (out_rider_count),
    .out_emergency_active (out_emergency_active),
    .out_car_busy         (out_car_busy),
    .out_last             (out_last)
  );

  a_result_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a transaction in flight");

  a_take_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result after the final one of a transaction");

  a_floor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_car_floor <= FLOOR_W'(TOP_FLOOR)))
    else $error("car floor beyond the top floor");

  a_doors_need_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_doors_cycled == (out_alighting || out_pickup)))
    else $error("door cycle without a served stop");

endmodule
